@@ sv/b64d_pkg.sv @@
// Shared types, constants and the character decode function for the
// Base64 stream decoder. No dependencies.
`timescale 1ns / 1ps

package b64d_pkg;

  // Sextet codes beyond the 64 alphabet values
  localparam logic [6:0] SEXTET_PAD = 7'd64;
  localparam logic [6:0] SEXTET_BAD = 7'd65;

  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

  // Group positions
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;
  localparam logic [1:0] PH_FOURTH = 2'd3;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One result item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       is_last;
    logic       error;
  } result_t;

  // All results caused by one input item; cnt is 1 to 3
  typedef struct packed {
    result_t [2:0] ent;
    logic [1:0]    cnt;
  } record_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_space(input logic [7:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
  endfunction

  // Map a character to its sextet, the pad code or the bad code
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = SEXTET_BAD;
    if (c >= "A" && c <= "Z")      v = 7'(c - 8'h41);
    else if (c >= "a" && c <= "z") v = 7'(c - 8'h61 + 8'd26);
    else if (c >= "0" && c <= "9") v = 7'(c - 8'h30 + 8'd52);
    else if (c == "+")             v = 7'd62;
    else if (c == "/")             v = 7'd63;
    else if (c == CHAR_PAD)        v = SEXTET_PAD;
    return v;
  endfunction

endpackage

@@ sv/b64d_front.sv @@
// Front end: accepts characters, tracks the open group and builds the
// record of results for each character. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_char,
  input  logic                in_last,
  input  b64d_pkg::q_status_t q_stat,
  output logic                push,
  output b64d_pkg::record_t   push_rec
);
  import b64d_pkg::*;

  logic [1:0]  phase_r, phase_nxt;
  logic [17:0] held_r, held_nxt;
  logic        tip_r, tip_nxt;
  logic        err_r, err_nxt;

  logic        accept;
  logic        space;
  logic [6:0]  v;
  logic [5:0]  v6;
  logic        emit;
  logic [7:0]  b0, b1, b2;
  logic [1:0]  n_emit;
  record_t     rec;
  logic        has_res;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  // Classify and advance the group state
  always_comb begin
    space     = is_space(in_char);
    v         = sextet_of(in_char);
    v6        = (v > 7'd63) ? 6'd0 : v[5:0];
    phase_nxt = phase_r;
    held_nxt  = held_r;
    tip_nxt   = tip_r;
    err_nxt   = err_r;
    emit      = 1'b0;
    if (!space) begin
      unique case (phase_r)
        PH_FIRST: begin
          if (v > 7'd63) err_nxt = 1'b1;
          held_nxt = {v[5:0], 12'd0};
          tip_nxt  = 1'b0;
        end
        PH_SECOND: begin
          if (v > 7'd63) err_nxt = 1'b1;
          held_nxt = held_r | {6'd0, v[5:0], 6'd0};
        end
        PH_THIRD: begin
          if (v == SEXTET_BAD) err_nxt = 1'b1;
          tip_nxt  = (v == SEXTET_PAD);
          held_nxt = held_r | {12'd0, v6};
        end
        PH_FOURTH: begin
          if (v == SEXTET_BAD) err_nxt = 1'b1;
          emit     = !err_nxt;
          held_nxt = 18'd0;
          tip_nxt  = 1'b0;
        end
        default: ;
      endcase
      phase_nxt = phase_r + 2'd1;
    end
  end

  // Build the compacted list of bytes for a completed group
  always_comb begin
    b0     = held_r[17:10];
    b1     = held_r[9:2];
    b2     = {held_r[1:0], v6};
    n_emit = 2'd0;
    if (emit) n_emit = 2'd1 + {1'b0, !tip_r} + {1'b0, v != SEXTET_PAD};

    rec                  = '0;
    rec.ent[0].data_byte = b0;
    rec.ent[1].data_byte = tip_r ? b2 : b1;
    rec.ent[2].data_byte = b2;
    rec.ent[0].byte_valid = 1'b1;
    rec.ent[1].byte_valid = 1'b1;
    rec.ent[2].byte_valid = 1'b1;
    rec.cnt = n_emit;
    has_res = (n_emit != 2'd0);

    // End of message: error marker, tag last byte, or empty marker
    if (in_last) begin
      has_res = 1'b1;
      if (err_nxt || (phase_nxt != PH_FIRST)) begin
        rec        = '0;
        rec.cnt    = 2'd1;
        rec.ent[0].is_last = 1'b1;
        rec.ent[0].error   = 1'b1;
      end else if (n_emit != 2'd0) begin
        case (n_emit)
          2'd1:    rec.ent[0].is_last = 1'b1;
          2'd2:    rec.ent[1].is_last = 1'b1;
          default: rec.ent[2].is_last = 1'b1;
        endcase
      end else begin
        rec        = '0;
        rec.cnt    = 2'd1;
        rec.ent[0].is_last = 1'b1;
      end
    end
  end

  assign push     = accept && has_res;
  assign push_rec = rec;

  // Update group state on each transfer; clear at end of message
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      held_r  <= '0;
      tip_r   <= 1'b0;
      err_r   <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        phase_r <= PH_FIRST;
        held_r  <= '0;
        tip_r   <= 1'b0;
        err_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
        tip_r   <= tip_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

@@ sv/b64d_queue.sv @@
// Short record queue between the front and back ends.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b64d_pkg::record_t   push_rec,
  input  logic                pop,
  output b64d_pkg::record_t   head_rec,
  output b64d_pkg::q_status_t q_stat
);
  import b64d_pkg::*;

  record_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_rec     = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_rec;
  end

endmodule

@@ sv/b64d_back.sv @@
// Back end: unpacks queued records into result transfers, one per cycle
// while out_stall is low, from a registered output record. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  b64d_pkg::record_t   head_rec,
  input  b64d_pkg::q_status_t q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_data_byte,
  output logic                out_byte_valid,
  output logic                out_is_last,
  output logic                out_error
);
  import b64d_pkg::*;

  record_t    cur_r;
  logic [1:0] idx_r;
  logic       cur_valid_r;
  logic       xfer;
  logic       at_end;
  result_t    sel;

  assign xfer   = cur_valid_r && !out_stall;
  assign at_end = (idx_r == cur_r.cnt - 2'd1);
  assign pop    = !q_stat.empty && (!cur_valid_r || (xfer && at_end));

  // Select the current entry
  always_comb begin
    case (idx_r)
      2'd0:    sel = cur_r.ent[0];
      2'd1:    sel = cur_r.ent[1];
      default: sel = cur_r.ent[2];
    endcase
  end

  assign out_valid      = cur_valid_r;
  assign out_data_byte  = sel.data_byte;
  assign out_byte_valid = sel.byte_valid;
  assign out_is_last    = sel.is_last;
  assign out_error      = sel.error;

  // Load the next record or advance within the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (xfer) begin
      if (at_end) cur_valid_r <= 1'b0;
      else        idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head_rec;
  end

endmodule

@@ sv/base64_stream_decoder.sv @@
// Top level of the Base64 stream decoder: front end, record queue and
// back end. Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   input   | in_valid, in_stall, in_char, in_last            | in
//   result  | out_valid, out_stall, out_data_byte,            | out
//           | out_byte_valid, out_is_last, out_error          |
//
// One character is taken per cycle while the four-entry record queue has
// room; the back end sends one result per cycle while out_stall is low, so a
// full group of three bytes gives three results, each via the queue memory
// and the back end's record register. Reset empties the queue and clears the
// group state. A stalled output fills the queue, and then in_stall rises.
`timescale 1ns / 1ps

module base64_stream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic       out_is_last,
  output logic       out_error
);
  import b64d_pkg::*;

  q_status_t q_stat;
  record_t   push_rec;
  record_t   head_rec;
  logic      push;
  logic      pop;

  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .in_last  (in_last),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .q_stat   (q_stat)
  );

  b64d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_rec       (head_rec),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_byte_valid (out_byte_valid),
    .out_is_last    (out_is_last),
    .out_error      (out_error)
  );

endmodule
